/* rtl/core/gbso_pkg.sv */
package gbso_pkg;

	localparam int NUM_CHIPS         = 3;
	localparam int CHANNELS_PER_CHIP = 16;
	localparam int PAIRS_PER_CHIP    = CHANNELS_PER_CHIP / 2;
	localparam int ROWS              = NUM_CHIPS * PAIRS_PER_CHIP;
	localparam int ROW_W             = $clog2(ROWS);
	localparam int LEVEL_W           = 12;
	localparam int GROUP_W           = 2 * LEVEL_W;
	localparam int QDEPTH            = 2;
	localparam int QPTR_W            = $clog2(QDEPTH);
	localparam int QCNT_W            = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_WR12  = 2'd0;
	localparam logic [1:0] MODE_WR8   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_SHIFT = 2'd3;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_SHIFT = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_SHIFT
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [ROW_W-1:0]   row;
		logic               odd;
		logic               in_range;
		logic [LEVEL_W-1:0] wdata;
	} cmd_t;

endpackage

/* rtl/core/gbso_ram.sv */
module gbso_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/gbso_front.sv */
module gbso_front import gbso_pkg::*; (
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic [1:0]         chip_index,
	input  logic [3:0]         channel,
	input  logic [LEVEL_W-1:0] level,
	output logic               push,
	output cmd_t               push_cmd
);

	logic in_range;

	assign in_range = int'(chip_index) < NUM_CHIPS;

	always_comb begin
		push              = 1'b0;
		push_cmd.op       = OP_WRITE;
		push_cmd.row      = ROW_W'({chip_index, channel[3:1]});
		push_cmd.odd      = channel[0];
		push_cmd.in_range = in_range;
		push_cmd.wdata    = level;
		case (mode)
			MODE_WR12: begin
				push = start && !busy && in_range;
			end
			MODE_WR8: begin
				push           = start && !busy && in_range;
				push_cmd.wdata = {level[7:0], level[7:4]};
			end
			MODE_READ: begin
				push        = start && !busy;
				push_cmd.op = OP_READ;
			end
			MODE_SHIFT: begin
				push        = start && !busy;
				push_cmd.op = OP_SHIFT;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/gbso_queue.sv */
module gbso_queue import gbso_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/gbso_back.sv */
module gbso_back import gbso_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               strobe,
	output logic               kind,
	output logic [LEVEL_W-1:0] read_level,
	output logic [GROUP_W-1:0] byte_group,
	output logic               last_group
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SHIFT = 2'b10
	} back_state_t;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	back_state_t        state_q, state_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [ROWS-1:0]    vld_even_q;
	logic [ROWS-1:0]    vld_odd_q;
	logic               issue;
	logic               issue_kind;
	logic               issue_last;
	logic [ROW_W-1:0]   issue_row;
	logic               we_even;
	logic               we_odd;
	logic [LEVEL_W-1:0] rdata_even;
	logic [LEVEL_W-1:0] rdata_odd;
	logic [LEVEL_W-1:0] lvl_even;
	logic [LEVEL_W-1:0] lvl_odd;

	logic               vld_s1;
	logic               kind_s1;
	logic               last_s1;
	logic               odd_s1;
	logic               zero_s1;
	logic               ve_s1;
	logic               vo_s1;

	logic               strobe_q;
	logic               kind_q;
	logic               last_q;
	logic [LEVEL_W-1:0] read_level_q;
	logic [GROUP_W-1:0] byte_group_q;

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		q_pop      = 1'b0;
		issue      = 1'b0;
		issue_kind = KIND_READ;
		issue_last = 1'b0;
		issue_row  = q_cmd.row;
		we_even    = 1'b0;
		we_odd     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						OP_WRITE: begin
							we_odd  = q_cmd.odd && q_cmd.in_range;
							we_even = !q_cmd.odd && q_cmd.in_range;
						end
						OP_READ: begin
							issue = 1'b1;
						end
						OP_SHIFT: begin
							state_d = ST_SHIFT;
							row_d   = ROW_LAST;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				issue      = 1'b1;
				issue_kind = KIND_SHIFT;
				issue_row  = row_q;
				issue_last = row_q == '0;
				if (row_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					row_d = row_q - 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	gbso_ram #(.WIDTH(LEVEL_W), .DEPTH(ROWS)) u_ram_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (q_cmd.row),
		.wdata (q_cmd.wdata),
		.raddr (issue_row),
		.rdata (rdata_even)
	);

	gbso_ram #(.WIDTH(LEVEL_W), .DEPTH(ROWS)) u_ram_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (q_cmd.row),
		.wdata (q_cmd.wdata),
		.raddr (issue_row),
		.rdata (rdata_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_q      <= '0;
			vld_even_q <= '0;
			vld_odd_q  <= '0;
			vld_s1     <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			vld_s1   <= issue;
			strobe_q <= vld_s1;
			if (we_even) begin
				vld_even_q[q_cmd.row] <= 1'b1;
			end
			if (we_odd) begin
				vld_odd_q[q_cmd.row] <= 1'b1;
			end
		end
	end

	// unwritten entries read as the reset value
	assign lvl_even = ve_s1 ? rdata_even : '0;
	assign lvl_odd  = vo_s1 ? rdata_odd  : '0;

	always_ff @(posedge clk) begin
		kind_s1 <= issue_kind;
		last_s1 <= issue_last;
		odd_s1  <= q_cmd.odd;
		zero_s1 <= !q_cmd.in_range;
		ve_s1   <= vld_even_q[issue_row];
		vo_s1   <= vld_odd_q[issue_row];

		kind_q <= kind_s1;
		last_q <= last_s1;
		if (kind_s1 == KIND_SHIFT) begin
			read_level_q <= '0;
			byte_group_q <= {lvl_odd, lvl_even};
		end else begin
			read_level_q <= zero_s1 ? '0 : (odd_s1 ? lvl_odd : lvl_even);
			byte_group_q <= '0;
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign last_group = last_q;
	assign read_level = read_level_q;
	assign byte_group = byte_group_q;

endmodule

/* rtl/core/grayscale_buffer_shift_out.sv */
// Writes take no result; a read reply strobes once the back end has taken it from
// the queue and it has passed the s1 and output registers. A shift-out gives
// NUM_CHIPS*8 groups on consecutive cycles; the back end takes no new command until its last group is issued.
// Commands transfer one per cycle into a two-entry queue; busy while it is full.
// Store rows are read one per cycle through the two RAM read ports.
// Reset clears the queue and marks every store entry as zero.
module grayscale_buffer_shift_out import gbso_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [1:0]         chip_index,
	input  logic [3:0]         channel,
	input  logic [LEVEL_W-1:0] level,
	output logic               strobe,
	output logic               kind,
	output logic [LEVEL_W-1:0] read_level,
	output logic [GROUP_W-1:0] byte_group,
	output logic               last_group
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	assign busy = q_full;

	gbso_front u_front (
		.start      (start),
		.busy       (q_full),
		.mode       (mode),
		.chip_index (chip_index),
		.channel    (channel),
		.level      (level),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	gbso_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	gbso_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_head),
		.q_pop      (q_pop),
		.strobe     (strobe),
		.kind       (kind),
		.read_level (read_level),
		.byte_group (byte_group),
		.last_group (last_group)
	);

endmodule
